### design/assert_macros.svh
// assertion macros for the fat12 table engine, used by fat12_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define FAT12_ASSERT(label, ck, rn, prop) \
  label: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("fat12 assertion failed");

// condition must never be true out of reset
`define FAT12_NEVER(label, ck, rn, cond) \
  label: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("fat12 forbidden condition seen");

`endif

### design/fat12_pkg.sv
// types and constants of the fat12 table engine
package fat12_pkg;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_FIND  = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  localparam logic [13:0] TABLE_BYTES_RST = 14'd4608;
  localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [12:0] byte_address;
    logic [7:0]  byte_value;
    logic [11:0] cluster;
    logic [11:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic [11:0] read_value;
    logic [11:0] free_cluster;
    logic [11:0] free_count;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic load;
    logic entry_rd;
    logic entry_fin;
    logic scan;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
  } dp_stat_t;

endpackage

### design/fat12_ram.sv
// generic single write port ram with registered read
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/fat12_ctrl.sv
// controller state machine of the fat12 table engine
`include "assert_macros.svh"

module fat12_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          opcode,
  output logic                busy,
  output logic                out_valid,
  output fat12_pkg::ctl_cmd_t cmd,
  input  fat12_pkg::dp_stat_t stat
);
  import fat12_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_EADDR = 7'b0001000,
    S_EDATA = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (opcode)
            OP_LOAD:           state_nxt = S_LOAD;
            OP_READ, OP_WRITE: state_nxt = S_EADDR;
            OP_FIND, OP_COUNT: state_nxt = S_SCAN;
            default:           state_nxt = S_RESP;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_RESP;
      end
      S_EADDR: begin
        cmd.entry_rd = 1'b1;
        state_nxt    = S_EDATA;
      end
      S_EDATA: begin
        cmd.entry_fin = 1'b1;
        state_nxt     = S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  `FAT12_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `FAT12_ASSERT(a_strobe_single, clk, rst_n, out_valid |=> (!out_valid && !busy))
  `FAT12_ASSERT(a_clear_then_idle, clk, rst_n, $fell(cmd.clear) |-> !busy)
  `FAT12_NEVER(a_no_store_write_idle, clk, rst_n, !busy && (cmd.load || cmd.clear))

endmodule

### design/fat12_dp.sv
// datapath of the fat12 table engine: byte banks, scan counter, result word
module fat12_dp #(
  parameter int MAX_TABLE_BYTES = 8192
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fat12_pkg::ctl_cmd_t  cmd,
  output fat12_pkg::dp_stat_t  stat,
  input  fat12_pkg::in_word_t  in_word,
  input  logic [13:0]          table_bytes,
  output fat12_pkg::out_word_t out_word
);
  import fat12_pkg::*;

  localparam int AW    = $clog2(MAX_TABLE_BYTES);
  localparam int BW    = AW - 1;
  localparam int DEPTH = MAX_TABLE_BYTES / 2;

  logic [2:0]    op_r;
  logic [AW-1:0] badr_r;
  logic [7:0]    bval_r;
  logic [11:0]   eval_r;
  logic [12:0]   c_r;
  logic          p_vld_r;
  logic          p_odd_r;
  logic          p_offodd_r;
  logic [11:0]   p_c_r;
  logic [BW-1:0] clr_r;
  out_word_t     res_r;

  logic [12:0]   off;
  logic [12:0]   off1;
  logic [13:0]   t_sat;
  logic          issue;
  logic [BW-1:0] ra_even;
  logic [BW-1:0] ra_odd;
  logic [7:0]    rd_even;
  logic [7:0]    rd_odd;
  logic [7:0]    lo;
  logic [7:0]    hi;
  logic [11:0]   ent;
  logic          ent_free;
  logic          hit;
  logic [7:0]    nlo;
  logic [7:0]    nhi;
  logic          wr_ent;
  logic          we_even;
  logic          we_odd;
  logic [BW-1:0] wa_even;
  logic [BW-1:0] wa_odd;
  logic [7:0]    wd_even;
  logic [7:0]    wd_odd;

  // byte offset of the entry, and the scan bound as a byte compare
  assign off   = {1'b0, c_r[11:0]} + {2'b00, c_r[11:1]};
  assign off1  = off + 13'd1;
  assign t_sat = (table_bytes > 14'(MAX_TABLE_BYTES)) ? 14'(MAX_TABLE_BYTES) : table_bytes;
  assign issue = !c_r[12] && (({1'b0, off} + 14'd2) <= t_sat);

  assign ra_odd  = off[AW-1:1];
  assign ra_even = off[0] ? off1[AW-1:1] : off[AW-1:1];

  assign lo       = p_offodd_r ? rd_odd : rd_even;
  assign hi       = p_offodd_r ? rd_even : rd_odd;
  assign ent      = p_odd_r ? {hi, lo[7:4]} : {hi[3:0], lo};
  assign ent_free = (ent == 12'd0);
  assign hit      = cmd.scan && p_vld_r && ent_free && (op_r == OP_FIND);

  // keep the nibble shared with the neighbor entry
  assign nlo = p_odd_r ? {eval_r[3:0], lo[3:0]} : eval_r[7:0];
  assign nhi = p_odd_r ? eval_r[11:4] : {hi[7:4], eval_r[11:8]};

  assign wr_ent = cmd.entry_fin && (op_r == OP_WRITE);

  always_comb begin
    we_even = 1'b0;
    we_odd  = 1'b0;
    wa_even = ra_even;
    wa_odd  = ra_odd;
    wd_even = p_offodd_r ? nhi : nlo;
    wd_odd  = p_offodd_r ? nlo : nhi;
    priority if (cmd.clear) begin
      we_even = 1'b1;
      we_odd  = 1'b1;
      wa_even = clr_r;
      wa_odd  = clr_r;
      wd_even = 8'd0;
      wd_odd  = 8'd0;
    end else if (cmd.load) begin
      we_even = !badr_r[0];
      we_odd  = badr_r[0];
      wa_even = badr_r[AW-1:1];
      wa_odd  = badr_r[AW-1:1];
      wd_even = bval_r;
      wd_odd  = bval_r;
    end else if (wr_ent) begin
      we_even = 1'b1;
      we_odd  = 1'b1;
    end else begin
      we_even = 1'b0;
      we_odd  = 1'b0;
    end
  end

  fat12_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (we_even),
    .waddr (wa_even),
    .wdata (wd_even),
    .raddr (ra_even),
    .rdata (rd_even)
  );

  fat12_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (we_odd),
    .waddr (wa_odd),
    .wdata (wd_odd),
    .raddr (ra_odd),
    .rdata (rd_odd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      p_vld_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.capture) begin
        p_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        p_vld_r <= issue && !hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_word.opcode;
      badr_r <= in_word.byte_address[AW-1:0];
      bval_r <= in_word.byte_value;
      eval_r <= in_word.entry_value;
      c_r    <= (in_word.opcode == OP_COUNT) ? {1'b0, FIRST_DATA_CLUSTER}
                                              : {1'b0, in_word.cluster};
      res_r  <= '0;
    end else begin
      if (cmd.scan && issue && !hit) begin
        c_r <= c_r + 13'd1;
      end
      if (cmd.entry_fin && (op_r == OP_READ)) begin
        res_r.read_value <= ent;
      end
      if (hit) begin
        res_r.free_cluster <= p_c_r;
      end
      if (cmd.scan && p_vld_r && ent_free && (op_r == OP_COUNT)) begin
        res_r.free_count <= res_r.free_count + 12'd1;
      end
    end
    if (cmd.scan || cmd.entry_rd) begin
      p_odd_r    <= c_r[0];
      p_offodd_r <= off[0];
      p_c_r      <= c_r[11:0];
    end
  end

  assign stat.clear_last = (clr_r == {BW{1'b1}});
  assign stat.scan_done  = hit || (!p_vld_r && !issue);
  assign out_word        = res_r;

endmodule

### design/fat12_table_engine.sv
// top level of the fat12 table engine: config register, controller, datapath
//
// An item is a command word on in_word, taken when start is high and busy
// is low. Operations: load a raw table byte, read or write a 12-bit entry,
// find the first free entry from a start cluster, count free entries from
// cluster 2. Each item gives one result word on out_word, marked by
// out_valid for a single cycle; the receiver must take it then.
// From the accept, a load byte passes the load state, a read or write
// entry the entry address and entry data states, and find and count the
// scan state over the entries visited; an unused opcode goes straight to
// the response state, in which out_valid is high. The scan reads one
// entry per cycle from two byte banks (even and odd bytes) so both bytes
// of an entry arrive together. One item is in flight at a time.
// After reset all MAX_TABLE_BYTES/2 rows of each bank are cleared one row
// per cycle, with busy high; table_bytes resets to 4608 and may be written
// over the APB port at any time while busy is low and no result is pending.
// MAX_TABLE_BYTES must be a power of two.
module fat12_table_engine #(
  parameter int MAX_TABLE_BYTES = 8192
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fat12_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output fat12_pkg::out_word_t out_word,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import fat12_pkg::*;

  logic [13:0] table_bytes_r;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_bytes_r <= TABLE_BYTES_RST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      table_bytes_r <= pwdata[13:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {18'd0, table_bytes_r};

  fat12_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_word.opcode),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  fat12_dp #(
    .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_word     (in_word),
    .table_bytes (table_bytes_r),
    .out_word    (out_word)
  );

endmodule

### bench/tb_fat12_table_engine.sv
// testbench for fat12_table_engine: directed and random table traffic checked against a predictor
module tb_fat12_table_engine;
  import fat12_pkg::*;

  localparam int TABLE_MAX = 8192;
  localparam int ENTRY_SPAN = 4096;
  localparam logic [2:0] CFG_TABLE_BYTES_ADDR = 3'd0;
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  fat_bytes [TABLE_MAX];
  logic [13:0] table_bytes_cfg;
  out_word_t   answers_due [$];
  int          error_count;
  int          words_sent;
  int          idle_pct;

  fat12_table_engine #(.MAX_TABLE_BYTES(TABLE_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [11:0] entry_at(input logic [11:0] c);
    logic [12:0] off;
    logic [15:0] pair;
    off = 13'(c) + 13'(c[11:1]);
    pair = {fat_bytes[off + 13'd1], fat_bytes[off]};
    return c[0] ? pair[15:4] : pair[11:0];
  endfunction

  function automatic void entry_store(input logic [11:0] c, input logic [11:0] v);
    logic [12:0] lo;
    logic [12:0] hi;
    lo = 13'(c) + 13'(c[11:1]);
    hi = lo + 13'd1;
    if (c[0]) begin
      fat_bytes[lo] = {v[3:0], fat_bytes[lo][3:0]};
      fat_bytes[hi] = v[11:4];
    end else begin
      fat_bytes[lo] = v[7:0];
      fat_bytes[hi] = {fat_bytes[hi][7:4], v[11:8]};
    end
  endfunction

  function automatic int scan_limit();
    int t;
    int n;
    t = (table_bytes_cfg > TABLE_MAX) ? TABLE_MAX : int'(table_bytes_cfg);
    n = (2 * t) / 3;
    return (n > ENTRY_SPAN) ? ENTRY_SPAN : n;
  endfunction

  function automatic out_word_t compute_answer(input in_word_t w);
    out_word_t r;
    int lim;
    int c;
    r = '0;
    lim = scan_limit();
    case (w.opcode)
      OP_LOAD: begin
        fat_bytes[w.byte_address] = w.byte_value;
      end
      OP_READ: begin
        r.read_value = entry_at(w.cluster);
      end
      OP_WRITE: begin
        entry_store(w.cluster, w.entry_value);
      end
      OP_FIND: begin
        for (c = int'(w.cluster); c < lim; c++) begin
          if (entry_at(12'(c)) == 12'd0) begin
            r.free_cluster = 12'(c);
            break;
          end
        end
      end
      OP_COUNT: begin
        for (c = int'(FIRST_DATA_CLUSTER); c < lim; c++) begin
          if (entry_at(12'(c)) == 12'd0) r.free_count = r.free_count + 12'd1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic in_word_t build_word(input logic [2:0] op, input logic [12:0] addr,
                                          input logic [7:0] bval, input logic [11:0] clus,
                                          input logic [11:0] eval);
    in_word_t w;
    w.opcode = op;
    w.byte_address = addr;
    w.byte_value = bval;
    w.cluster = clus;
    w.entry_value = eval;
    return w;
  endfunction

  always @(posedge clk) begin
    out_word_t seen;
    out_word_t want;
    if (rst_n && out_valid) begin
      seen = out_word;
      if (answers_due.size() == 0) begin
        flag_error($sformatf("unexpected result word %h", seen));
      end else begin
        want = answers_due.pop_front();
        if (seen.read_value !== want.read_value)
          flag_error($sformatf("read_value %h, expected %h", seen.read_value, want.read_value));
        if (seen.free_cluster !== want.free_cluster)
          flag_error($sformatf("free_cluster %h, expected %h",
                               seen.free_cluster, want.free_cluster));
        if (seen.free_count !== want.free_count)
          flag_error($sformatf("free_count %h, expected %h", seen.free_count, want.free_count));
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    @(negedge clk);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    answers_due.push_back(compute_answer(w));
    words_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        in_word <= 48'({$urandom(), $urandom()});
      end
    end
  endtask

  task automatic wait_until_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (busy || answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_table_bytes(input logic [13:0] v);
    wait_until_quiet();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_TABLE_BYTES_ADDR;
    pwdata <= {18'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    table_bytes_cfg = v;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {18'd0, v})
      flag_error($sformatf("table_bytes reads %h, expected %h", prdata, v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_byte_loads();
    send_word(build_word(OP_LOAD, 13'd0, 8'hFF, 12'd0, 12'd0));
    send_word(build_word(OP_LOAD, 13'd8191, 8'hA5, 12'hFFF, 12'hFFF));
    send_word(build_word(OP_LOAD, 13'd1, 8'h00, 12'd0, 12'd0));
    send_word(build_word(OP_READ, 13'd0, 8'h00, 12'd0, 12'd0));
  endtask

  task automatic test_entry_access();
    send_word(build_word(OP_WRITE, 13'd0, 8'h00, 12'd2, 12'hFFF));
    send_word(build_word(OP_WRITE, 13'd0, 8'h00, 12'd3, 12'hABC));
    send_word(build_word(OP_READ, 13'd0, 8'h00, 12'd2, 12'd0));
    send_word(build_word(OP_WRITE, 13'd0, 8'h00, 12'd3, 12'h000));
    send_word(build_word(OP_READ, 13'd0, 8'h00, 12'd2, 12'd0));
    send_word(build_word(OP_READ, 13'd0, 8'h00, 12'd3, 12'd0));
    send_word(build_word(OP_WRITE, 13'h1FFF, 8'hFF, 12'd4095, 12'hFFF));
    send_word(build_word(OP_READ, 13'd0, 8'h00, 12'd4095, 12'd0));
  endtask

  task automatic test_find_edges();
    // free entry 0 reads back as 0, same as nothing free
    send_word(build_word(OP_WRITE, 13'd0, 8'h00, 12'd0, 12'h000));
    send_word(build_word(OP_FIND, 13'd0, 8'h00, 12'd0, 12'd0));
    send_word(build_word(OP_FIND, 13'd0, 8'h00, 12'd1, 12'd0));
    send_word(build_word(OP_FIND, 13'd0, 8'h00, 12'd4095, 12'd0));
    send_word(build_word(OP_COUNT, 13'd0, 8'h00, 12'd0, 12'd0));
    // tiny table, every entry taken
    set_table_bytes(14'd6);
    send_word(build_word(OP_WRITE, 13'd0, 8'h00, 12'd0, 12'h001));
    send_word(build_word(OP_WRITE, 13'd0, 8'h00, 12'd1, 12'h800));
    send_word(build_word(OP_WRITE, 13'd0, 8'h00, 12'd3, 12'hFF7));
    send_word(build_word(OP_FIND, 13'd0, 8'h00, 12'd0, 12'd0));
    send_word(build_word(OP_COUNT, 13'd0, 8'h00, 12'd0, 12'd0));
  endtask

  task automatic test_table_sizes();
    set_table_bytes(14'd0);
    send_word(build_word(OP_FIND, 13'd0, 8'h00, 12'd0, 12'd0));
    send_word(build_word(OP_COUNT, 13'd0, 8'h00, 12'd0, 12'd0));
    set_table_bytes(14'h3FFF);
    send_word(build_word(OP_COUNT, 13'd0, 8'h00, 12'd0, 12'd0));
    set_table_bytes(14'd8192);
    send_word(build_word(OP_FIND, 13'd0, 8'h00, 12'd4000, 12'd0));
  endtask

  task automatic test_unused_ops();
    send_word(build_word(OP_SPARE_5, 13'h1FFF, 8'hFF, 12'hFFF, 12'hFFF));
    send_word(build_word(OP_SPARE_6, 13'd0, 8'h00, 12'd2, 12'h123));
    send_word(build_word(OP_SPARE_7, 13'd100, 8'h5A, 12'd5, 12'd0));
  endtask

  task automatic run_random_phase(input int pct, input logic [13:0] tbytes, input int quota);
    int first;
    int span;
    int base;
    int k;
    int i;
    logic [11:0] v;
    set_table_bytes(tbytes);
    idle_pct = pct;
    first = words_sent;
    span = scan_limit() + 8;
    if (span > ENTRY_SPAN) span = ENTRY_SPAN;
    while (words_sent - first < quota) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          // fill a run of entries, then look for space from its start or read one of them back
          base = $urandom_range(span - 1);
          k = $urandom_range(2, 8);
          for (i = 0; i < k; i++) begin
            v = 12'($urandom_range(1, 4095));
            send_word(build_word(OP_WRITE, 13'($urandom), 8'($urandom), 12'(base + i), v));
          end
          if ($urandom_range(1))
            send_word(build_word(OP_FIND, 13'($urandom), 8'($urandom), 12'(base), 12'($urandom)));
          else
            send_word(build_word(OP_READ, 13'($urandom), 8'($urandom),
                                 12'(base + $urandom_range(k - 1)), 12'($urandom)));
        end
        3: begin
          if ($urandom_range(1))
            send_word(build_word(OP_LOAD, 13'($urandom_range(2 * span)), 8'($urandom),
                                 12'($urandom), 12'($urandom)));
          else
            send_word(build_word(OP_LOAD, 13'($urandom), 8'($urandom),
                                 12'($urandom), 12'($urandom)));
        end
        4, 5: begin
          base = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(span - 1);
          v = ($urandom_range(9) < 3) ? 12'd0 : 12'($urandom);
          send_word(build_word(OP_WRITE, 13'($urandom), 8'($urandom), 12'(base), v));
        end
        6: begin
          base = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(span - 1);
          send_word(build_word(OP_READ, 13'($urandom), 8'($urandom), 12'(base), 12'($urandom)));
        end
        7: begin
          base = ($urandom_range(5) == 0) ? $urandom_range(4095) : $urandom_range(span - 1);
          send_word(build_word(OP_FIND, 13'($urandom), 8'($urandom), 12'(base), 12'($urandom)));
        end
        8: begin
          send_word(build_word(OP_COUNT, 13'($urandom), 8'($urandom),
                               12'($urandom), 12'($urandom)));
        end
        default: begin
          if ($urandom_range(1))
            wait_until_quiet();
          else
            send_word(build_word(3'($urandom_range(5, 7)), 13'($urandom), 8'($urandom),
                                 12'($urandom), 12'($urandom)));
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 14'($urandom_range(3, 200)), 27);
    run_random_phase(55, 14'($urandom_range(200, 1536)), 27);
    run_random_phase(0, 14'($urandom_range(8193, 16383)), 27);
    run_random_phase(31, 14'($urandom_range(0, 1536)), 27);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    words_sent = 0;
    idle_pct = 0;
    table_bytes_cfg = TABLE_BYTES_RST;
    foreach (fat_bytes[i]) fat_bytes[i] = 8'h00;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_byte_loads();
    test_entry_access();
    test_find_edges();
    test_table_sizes();
    test_unused_ops();
    test_random_traffic();

    wait_until_quiet();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    repeat (3000000) @(posedge clk);
    $display("ERROR: run timed out");
    $display("Test completed with failures");
    $finish;
  end

endmodule
